// ===== sv/sbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the shuffle bag sequencer.
// Holds the microcode ROM, the LFSR constants and the field widths; no dependencies.
package sbs_pkg;

  // Field widths and stream packing
  localparam int ITEM_W        = 10;
  localparam int COUNT_IN_W    = 11;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 16;
  localparam int LFSR_W        = 32;
  localparam int MAX_ITEMS_DEF = 1024;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 32'h0000_0001;

  // Operation codes carried on in_tuser
  localparam logic OP_TOGGLE  = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Microcode address width and step labels
  localparam int UPC_W = 5;

  localparam logic [UPC_W-1:0] STEP_IDLE       = 5'd0;
  localparam logic [UPC_W-1:0] STEP_DISPATCH   = 5'd1;
  localparam logic [UPC_W-1:0] STEP_TOGGLE     = 5'd2;
  localparam logic [UPC_W-1:0] STEP_CHECK_FILL = 5'd3;
  localparam logic [UPC_W-1:0] STEP_FILL_INIT  = 5'd4;
  localparam logic [UPC_W-1:0] STEP_FILL       = 5'd5;
  localparam logic [UPC_W-1:0] STEP_SHUF_INIT  = 5'd6;
  localparam logic [UPC_W-1:0] STEP_SHUF_TEST  = 5'd7;
  localparam logic [UPC_W-1:0] STEP_SWAP_START = 5'd8;
  localparam logic [UPC_W-1:0] STEP_DIV_WAIT   = 5'd9;
  localparam logic [UPC_W-1:0] STEP_READ_J     = 5'd10;
  localparam logic [UPC_W-1:0] STEP_WRITE_I    = 5'd11;
  localparam logic [UPC_W-1:0] STEP_WRITE_J    = 5'd12;
  localparam logic [UPC_W-1:0] STEP_AFTER_SHUF = 5'd13;
  localparam logic [UPC_W-1:0] STEP_ADV_CHECK  = 5'd14;
  localparam logic [UPC_W-1:0] STEP_ADV_POS    = 5'd15;
  localparam logic [UPC_W-1:0] STEP_ADV_READ   = 5'd16;
  localparam logic [UPC_W-1:0] STEP_ADV_CAP    = 5'd17;
  localparam logic [UPC_W-1:0] STEP_EMIT       = 5'd18;
  localparam logic [UPC_W-1:0] STEP_RETURN     = 5'd19;

  // Jump conditions: taken jumps go to target, otherwise the step counter advances
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_OP_ADV,
    C_OP_TOGGLE,
    C_NO_RUN,
    C_FILL_MORE,
    C_IDX_ZERO,
    C_DIV_BUSY,
    C_POS_USED,
    C_OUT_BUSY
  } cond_t;

  // Datapath actions, one per step
  typedef enum logic [3:0] {
    A_NONE,
    A_TOGGLE,
    A_IDX_CLR,
    A_FILL_WR,
    A_SHUF_INIT,
    A_SWAP_START,
    A_CAP_I,
    A_READ_J,
    A_WRITE_I,
    A_WRITE_J,
    A_ADV_READ,
    A_ADV_CAP,
    A_EMIT
  } act_t;

  typedef struct packed {
    cond_t             cond;
    act_t              act;
    logic [UPC_W-1:0]  target;
  } ucode_t;

  // Control program
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    w = '{cond: C_ALWAYS, act: A_NONE, target: STEP_IDLE};
    case (addr)
      STEP_IDLE:       w = '{cond: C_NO_INPUT,  act: A_NONE,       target: STEP_IDLE};
      STEP_DISPATCH:   w = '{cond: C_OP_ADV,    act: A_NONE,       target: STEP_ADV_CHECK};
      STEP_TOGGLE:     w = '{cond: C_NEVER,     act: A_TOGGLE,     target: STEP_IDLE};
      STEP_CHECK_FILL: w = '{cond: C_NO_RUN,    act: A_NONE,       target: STEP_EMIT};
      STEP_FILL_INIT:  w = '{cond: C_NEVER,     act: A_IDX_CLR,    target: STEP_IDLE};
      STEP_FILL:       w = '{cond: C_FILL_MORE, act: A_FILL_WR,    target: STEP_FILL};
      STEP_SHUF_INIT:  w = '{cond: C_NEVER,     act: A_SHUF_INIT,  target: STEP_IDLE};
      STEP_SHUF_TEST:  w = '{cond: C_IDX_ZERO,  act: A_NONE,       target: STEP_AFTER_SHUF};
      STEP_SWAP_START: w = '{cond: C_NEVER,     act: A_SWAP_START, target: STEP_IDLE};
      STEP_DIV_WAIT:   w = '{cond: C_DIV_BUSY,  act: A_CAP_I,      target: STEP_DIV_WAIT};
      STEP_READ_J:     w = '{cond: C_NEVER,     act: A_READ_J,     target: STEP_IDLE};
      STEP_WRITE_I:    w = '{cond: C_NEVER,     act: A_WRITE_I,    target: STEP_IDLE};
      STEP_WRITE_J:    w = '{cond: C_ALWAYS,    act: A_WRITE_J,    target: STEP_SHUF_TEST};
      STEP_AFTER_SHUF: w = '{cond: C_OP_TOGGLE, act: A_NONE,       target: STEP_EMIT};
      STEP_ADV_CHECK:  w = '{cond: C_NO_RUN,    act: A_NONE,       target: STEP_EMIT};
      STEP_ADV_POS:    w = '{cond: C_POS_USED,  act: A_NONE,       target: STEP_SHUF_INIT};
      STEP_ADV_READ:   w = '{cond: C_NEVER,     act: A_ADV_READ,   target: STEP_IDLE};
      STEP_ADV_CAP:    w = '{cond: C_NEVER,     act: A_ADV_CAP,    target: STEP_IDLE};
      STEP_EMIT:       w = '{cond: C_OUT_BUSY,  act: A_EMIT,       target: STEP_EMIT};
      STEP_RETURN:     w = '{cond: C_ALWAYS,    act: A_NONE,       target: STEP_IDLE};
      default:         w = '{cond: C_ALWAYS,    act: A_NONE,       target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/sbs_modulo.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on sbs_pkg for the dividend width.
module sbs_modulo
  import sbs_pkg::*;
#(
  parameter int DivW = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LFSR_W-1:0] dividend,
  input  logic [DivW-1:0]   divisor,
  output logic              busy,
  output logic [DivW-1:0]   remainder
);

  localparam int StepW = $clog2(LFSR_W + 1);

  logic [LFSR_W-1:0] quo_r,  quo_nxt;
  logic [DivW-1:0]   rem_r,  rem_nxt;
  logic [DivW-1:0]   div_r,  div_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic [DivW:0]     trial;

  // Shift in one dividend bit and subtract the divisor when it fits
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[LFSR_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      step_nxt = StepW'(LFSR_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DivW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[DivW-1:0];
      end
      quo_nxt  = {quo_r[LFSR_W-2:0], 1'b0};
      step_nxt = step_r - StepW'(1);
      busy_nxt = (step_r != StepW'(1));
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

// ===== sv/shuffle_bag_sequencer.sv =====
`timescale 1ns / 1ps
// Shuffle bag sequencer: a microcoded Fisher-Yates shuffle over a permutation table, LFSR driven.
// A toggle that enables with N > 1 fills the table and shuffles it; each swap waits on the
// 32-step bit-serial remainder. An advance that finds the table used up reshuffles it first.
// One transaction at a time: the next is accepted once the result register has loaded and the
// sequencer has stepped through its return step back to idle.
// Reset (synchronous, active low) clears flags, position, count and loads the LFSR with 1.
module shuffle_bag_sequencer
  import sbs_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Seed register write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LFSR_W-1:0]     cfg_data,    // random_seed
  // Command stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [10:0] item_count, rest zero
  input  logic [0:0]            in_tuser,    // [0] op
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [9:0] next_item, [10] enabled, rest zero
  output logic [0:0]            out_tuser    // [0] jump
);

  localparam int CntW = $clog2(MAX_ITEMS + 1);
  localparam int AddrW = $clog2(MAX_ITEMS);

  // Sequencer
  logic [UPC_W-1:0]  upc_r, upc_nxt;
  ucode_t            uw;
  logic              cond_hit;

  // Architectural state
  logic              on_r,  on_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [CntW-1:0]   pos_r, pos_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt, lfsr_step;

  // Working registers
  logic              op_r;
  logic [COUNT_IN_W-1:0] count_r;
  logic [CntW-1:0]   idx_r, idx_nxt;
  logic [AddrW-1:0]  j_r, j_nxt;
  logic [ITEM_W-1:0] tmp_r, tmp_nxt;
  logic [ITEM_W-1:0] item_r, item_nxt;
  logic              jump_r, jump_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [ITEM_W-1:0] out_item_r;
  logic              out_jump_r;
  logic              out_en_r;
  logic              out_busy;
  logic              out_load;

  // Table memory
  logic [ITEM_W-1:0] mem [MAX_ITEMS];
  logic [ITEM_W-1:0] mem_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_wa, mem_ra;
  logic [ITEM_W-1:0] mem_wd;

  // Remainder unit
  logic              div_start;
  logic              div_busy;
  logic [CntW-1:0]   div_rem;

  logic              in_acc;
  logic              run_ok;
  logic [31:0]       count_wide;
  logic [CntW-1:0]   count_sat;

  assign uw        = ucode_rom(upc_r);
  assign in_tready = (upc_r == STEP_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid_r && !out_tready;
  assign run_ok    = on_r && (cnt_r > CntW'(1));

  // Saturate the requested count to the table size
  assign count_wide = 32'(count_r);
  assign count_sat  = (count_wide > 32'(MAX_ITEMS)) ? CntW'(MAX_ITEMS) : CntW'(count_wide);

  // Galois LFSR step
  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);

  // Evaluate the jump condition of the current step
  always_comb begin
    case (uw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_INPUT:  cond_hit = !in_tvalid;
      C_OP_ADV:    cond_hit = (op_r == OP_ADVANCE);
      C_OP_TOGGLE: cond_hit = (op_r == OP_TOGGLE);
      C_NO_RUN:    cond_hit = !run_ok;
      C_FILL_MORE: cond_hit = (idx_r != (cnt_r - CntW'(1)));
      C_IDX_ZERO:  cond_hit = (idx_r == '0);
      C_DIV_BUSY:  cond_hit = div_busy;
      C_POS_USED:  cond_hit = (pos_r >= cnt_r);
      C_OUT_BUSY:  cond_hit = out_busy;
      default:     cond_hit = 1'b0;
    endcase
  end

  // Step counter: jump on a taken condition, otherwise step on
  always_comb begin
    upc_nxt = cond_hit ? uw.target : (upc_r + UPC_W'(1));
  end

  // Datapath actions
  always_comb begin
    on_nxt        = on_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    lfsr_nxt      = lfsr_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    tmp_nxt       = tmp_r;
    item_nxt      = item_r;
    jump_nxt      = jump_r;
    out_load      = 1'b0;
    div_start     = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = idx_r[AddrW-1:0];
    mem_wd        = ITEM_W'(idx_r);
    mem_re        = 1'b0;
    mem_ra        = idx_r[AddrW-1:0];
    case (uw.act)
      A_NONE: begin
      end
      A_TOGGLE: begin
        on_nxt = !on_r;
        if (!on_r) begin
          cnt_nxt = count_sat;
        end
      end
      A_IDX_CLR: begin
        idx_nxt = '0;
      end
      A_FILL_WR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + CntW'(1);
      end
      A_SHUF_INIT: begin
        idx_nxt = cnt_r - CntW'(1);
        pos_nxt = '0;
      end
      A_SWAP_START: begin
        lfsr_nxt  = lfsr_step;
        div_start = 1'b1;
        mem_re    = 1'b1;
      end
      A_CAP_I: begin
        tmp_nxt = mem_q;
      end
      A_READ_J: begin
        j_nxt  = div_rem[AddrW-1:0];
        mem_re = 1'b1;
        mem_ra = div_rem[AddrW-1:0];
      end
      A_WRITE_I: begin
        mem_we = 1'b1;
        mem_wd = mem_q;
      end
      A_WRITE_J: begin
        mem_we  = 1'b1;
        mem_wa  = j_r;
        mem_wd  = tmp_r;
        idx_nxt = idx_r - CntW'(1);
      end
      A_ADV_READ: begin
        mem_re  = 1'b1;
        mem_ra  = pos_r[AddrW-1:0];
        pos_nxt = pos_r + CntW'(1);
      end
      A_ADV_CAP: begin
        item_nxt = mem_q;
        jump_nxt = 1'b1;
      end
      A_EMIT: begin
        out_load = !out_busy;
      end
      default: begin
      end
    endcase
    // Clear the result on every accepted transaction
    if (in_acc) begin
      item_nxt = '0;
      jump_nxt = 1'b0;
    end
    // Seed write reloads the LFSR; zero would lock it
    if (cfg_valid && cfg_ready) begin
      lfsr_nxt = (cfg_data == '0) ? LFSR_ONE : cfg_data;
    end
  end

  // Output register: drop on take, load at emit
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= STEP_IDLE;
      on_r        <= 1'b0;
      cnt_r       <= '0;
      pos_r       <= '0;
      lfsr_r      <= LFSR_ONE;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      on_r        <= on_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser[0];
      count_r <= in_tdata[COUNT_IN_W-1:0];
    end
    idx_r  <= idx_nxt;
    j_r    <= j_nxt;
    tmp_r  <= tmp_nxt;
    item_r <= item_nxt;
    jump_r <= jump_nxt;
    if (out_load) begin
      out_item_r <= item_r;
      out_jump_r <= jump_r;
      out_en_r   <= on_r;
    end
  end

  // Permutation table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  sbs_modulo #(
    .DivW (CntW)
  ) u_modulo (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (lfsr_step),
    .divisor   (idx_r + CntW'(1)),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_en_r, out_item_r});
  assign out_tuser  = out_jump_r;

  // The table is never written while a remainder is still being formed
  a_no_write_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !div_busy)
    else $error("table write while remainder unit busy");

  // A swap partner never lies above the current swap index
  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.act == A_READ_J) |-> ((CntW + 1)'(div_rem) <= (CntW + 1)'(idx_r)))
    else $error("swap partner out of range");

  // One transaction at a time: after an accept the input side closes
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while busy");

  // A jump result is only produced while shuffling is enabled
  a_jump_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_jump_r) |-> out_en_r)
    else $error("jump result with shuffle disabled");

  // The step counter stays inside the program
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= STEP_RETURN)
    else $error("step counter outside program");

endmodule
